// ===== rtl/ofrb_pkg.sv =====
// Shared types and constants for the overlapping frame ring buffer.
// Command and status codes, register indexes and the per-word result info.
// No dependencies.
`default_nettype none

package ofrb_pkg;

   localparam int CFG_W     = 13;
   localparam int OFFSET_W  = 12;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 13'd1024;
   localparam logic [CFG_W-1:0] HOP_SIZE_RESET   = 13'd512;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOP_SIZE   = 2'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_NOT_READY  = 2'd1,
      STAT_BAD_OFFSET = 2'd2
   } status_type;

   // Everything about one word except the sample itself, which comes from the RAM.
   typedef struct packed {
      logic       rd_ok;
      logic       frame_ready;
      status_type status;
      logic       overrun;
   } item_info_type;

endpackage

`default_nettype wire

// ===== rtl/ofrb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module ofrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ofrb_ctrl.sv =====
// Pointer and fill-count control: config registers, command decode, RAM addresses.
// Depends on ofrb_pkg.
`default_nettype none

module ofrb_ctrl #(
   parameter int BUFFER_DEPTH = 16384,
   parameter int MAX_FRAME    = 4096,
   parameter int PTR_W        = $clog2(BUFFER_DEPTH),
   parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [ofrb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ofrb_pkg::CFG_W-1:0]         csr_wdata,
   input  wire logic                               accept,
   input  wire logic [ofrb_pkg::CMD_W-1:0]         command,
   input  wire logic [ofrb_pkg::OFFSET_W-1:0]      frame_offset,
   output logic                                    wr_en,
   output logic      [PTR_W-1:0]                   wr_addr,
   output logic                                    rd_en,
   output logic      [PTR_W-1:0]                   rd_addr,
   output ofrb_pkg::item_info_type                 info
);

   localparam int CFG_W = ofrb_pkg::CFG_W;

   logic [CFG_W-1:0] frame_size_ff, hop_size_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] window_ff, window_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             overrun_ff, overrun_in;

   logic [CFG_W-1:0] frame_eff, hop_eff;
   logic             ready_now;
   logic [PTR_W:0]   rd_sum, wr_sum, win_sum;
   ofrb_pkg::cmd_type cmd;

   assign cmd = ofrb_pkg::cmd_type'(command);

   always_comb begin
      // Clamp frame to [1, MAX_FRAME] and hop to [1, frame].
      if (frame_size_ff == '0) begin
         frame_eff = CFG_W'(1);
      end else if (frame_size_ff > CFG_W'(MAX_FRAME)) begin
         frame_eff = CFG_W'(MAX_FRAME);
      end else begin
         frame_eff = frame_size_ff;
      end
      if (hop_size_ff == '0) begin
         hop_eff = CFG_W'(1);
      end else if (hop_size_ff > frame_eff) begin
         hop_eff = frame_eff;
      end else begin
         hop_eff = hop_size_ff;
      end
   end

   assign ready_now = fill_ff >= CNT_W'(frame_eff);

   // Sums stay below twice the depth, so one conditional subtract wraps them.
   assign rd_sum  = (PTR_W+1)'(window_ff) + (PTR_W+1)'(frame_offset);
   assign wr_sum  = (PTR_W+1)'(wr_ptr_ff) + (PTR_W+1)'(1);
   assign win_sum = (PTR_W+1)'(window_ff) + (PTR_W+1)'(hop_eff);

   assign rd_addr = (rd_sum >= (PTR_W+1)'(BUFFER_DEPTH)) ?
                    PTR_W'(rd_sum - (PTR_W+1)'(BUFFER_DEPTH)) : PTR_W'(rd_sum);
   assign wr_addr = wr_ptr_ff;

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      window_in   = window_ff;
      fill_in     = fill_ff;
      overrun_in  = overrun_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      info.rd_ok  = 1'b0;
      info.status = ofrb_pkg::STAT_OK;
      if (accept) begin
         case (cmd)
            ofrb_pkg::CMD_PUSH: begin
               wr_en     = 1'b1;
               wr_ptr_in = (wr_sum >= (PTR_W+1)'(BUFFER_DEPTH)) ?
                           PTR_W'(wr_sum - (PTR_W+1)'(BUFFER_DEPTH)) : PTR_W'(wr_sum);
               if (fill_ff >= CNT_W'(BUFFER_DEPTH)) begin
                  overrun_in = 1'b1;
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
            ofrb_pkg::CMD_READ: begin
               if (!ready_now) begin
                  info.status = ofrb_pkg::STAT_NOT_READY;
               end else if (CFG_W'(frame_offset) >= frame_eff) begin
                  info.status = ofrb_pkg::STAT_BAD_OFFSET;
               end else begin
                  rd_en      = 1'b1;
                  info.rd_ok = 1'b1;
               end
            end
            ofrb_pkg::CMD_RELEASE: begin
               if (!ready_now) begin
                  info.status = ofrb_pkg::STAT_NOT_READY;
               end else begin
                  window_in = (win_sum >= (PTR_W+1)'(BUFFER_DEPTH)) ?
                              PTR_W'(win_sum - (PTR_W+1)'(BUFFER_DEPTH)) : PTR_W'(win_sum);
                  fill_in   = fill_ff - CNT_W'(hop_eff);
               end
            end
            default: begin
            end
         endcase
      end
      info.frame_ready = fill_in >= CNT_W'(frame_eff);
      info.overrun     = overrun_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= ofrb_pkg::FRAME_SIZE_RESET;
         hop_size_ff   <= ofrb_pkg::HOP_SIZE_RESET;
         wr_ptr_ff     <= '0;
         window_ff     <= '0;
         fill_ff       <= '0;
         overrun_ff    <= 1'b0;
      end else begin
         if (csr_we && csr_index == ofrb_pkg::CSR_FRAME_SIZE) begin
            frame_size_ff <= csr_wdata;
         end
         if (csr_we && csr_index == ofrb_pkg::CSR_HOP_SIZE) begin
            hop_size_ff <= csr_wdata;
         end
         wr_ptr_ff  <= wr_ptr_in;
         window_ff  <= window_in;
         fill_ff    <= fill_in;
         overrun_ff <= overrun_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(BUFFER_DEPTH))
      else $error("fill count above buffer depth");

   a_overrun_sticky: assert property (@(posedge clock) disable iff (reset)
      overrun_ff |=> overrun_ff)
      else $error("overrun flag cleared without reset");

   a_overrun_cause: assert property (@(posedge clock) disable iff (reset)
      (!overrun_ff && overrun_in) |-> (wr_en && fill_ff == CNT_W'(BUFFER_DEPTH)))
      else $error("overrun set without a push into a full store");

endmodule

`default_nettype wire

// ===== rtl/overlapping_frame_ring_buffer.sv =====
// Overlapping frame ring buffer, top level: handshake, read stage, output register.
// Depends on ofrb_pkg, ofrb_ctrl and ofrb_ram.
//
// Usage: req_* carries one command word (push a sample, read a frame sample at
// an offset from the window start, or release the frame by one hop). Every
// accepted word yields exactly one rsp_* word: the sample read (zero unless the
// read succeeded), frame_ready after the command, a status code and the sticky
// overrun flag. csr_* writes frame_size (index 0) and hop_size (index 1) with
// no wait; write them only while no word is in flight.
// Response path: the RAM is read at the accepting edge into the read stage, then
// the word moves on to the output register, where the receiver takes it.
// Throughput: one word per cycle while the receiver takes words, set by the
// single RAM read port and the pointer and fill-count update.
// Reset returns pointers, fill count, overrun flag and both registers to their
// defaults; sample storage is not cleared, and no clearing pass runs.
// When the receiver stalls, the output register holds its word and the read
// stage holds one more; req_ready drops only when both are occupied.
`default_nettype none

module overlapping_frame_ring_buffer #(
   parameter int BUFFER_DEPTH = 16384,
   parameter int MAX_FRAME    = 4096,
   parameter int SAMPLE_BITS  = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic        [ofrb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [ofrb_pkg::CFG_W-1:0]      csr_wdata,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic        [ofrb_pkg::CMD_W-1:0]      req_command,
   input  wire logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   input  wire logic        [ofrb_pkg::OFFSET_W-1:0]   req_frame_offset,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic                                        rsp_frame_ready,
   output logic             [ofrb_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                        rsp_overrun
);

   localparam int PTR_W = $clog2(BUFFER_DEPTH);

   logic                    accept;
   logic                    s1_adv;
   logic                    s1_valid_ff, s1_valid_in;
   ofrb_pkg::item_info_type info, s1_info_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  rsp_sample_ff;
   ofrb_pkg::item_info_type rsp_info_ff;

   logic                    wr_en, rd_en;
   logic [PTR_W-1:0]        wr_addr, rd_addr;
   logic [SAMPLE_BITS-1:0]  rd_data;

   // Read stage advances when the output register is empty or being drained.
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   ofrb_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .MAX_FRAME    (MAX_FRAME)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .command      (req_command),
      .frame_offset (req_frame_offset),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .info         (info)
   );

   ofrb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload; RAM read data holds until the next read, so a stalled stage stays intact.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      if (s1_adv) begin
         rsp_info_ff   <= s1_info_ff;
         rsp_sample_ff <= s1_info_ff.rd_ok ? rd_data : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_frame_ready = rsp_info_ff.frame_ready;
   assign rsp_status      = rsp_info_ff.status;
   assign rsp_overrun     = rsp_info_ff.overrun;

   a_rd_ok_status: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_info_ff.rd_ok) |-> (s1_info_ff.status == ofrb_pkg::STAT_OK))
      else $error("successful read carries a failure status");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_valid_ff || s1_adv))
      else $error("word accepted over an occupied read stage");

   a_adv_delivers: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("read stage advanced but output register is empty");

   a_read_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (accept && info.rd_ok))
      else $error("RAM read outside an accepted successful read");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for overlapping_frame_ring_buffer: directed and random command words,
// a word-level prediction of the ring state, random idling on both channels.
// Depends on ofrb_pkg and the overlapping_frame_ring_buffer RTL.
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH       = 16384;
   localparam int MAX_FRAME   = 4096;
   localparam int STALL_LIMIT = 4000;

   // register indexes past the end of the list; writes there must be ignored
   localparam logic [ofrb_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [ofrb_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [15:0]          sample;
      logic                 frame_ready;
      ofrb_pkg::status_type status;
      logic                 overrun;
   } ring_word_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_we;
   logic [ofrb_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ofrb_pkg::CFG_W-1:0]      csr_wdata;
   logic                            req_valid;
   logic                            req_ready;
   logic [ofrb_pkg::CMD_W-1:0]      req_command;
   logic signed [15:0]              req_sample_in;
   logic [ofrb_pkg::OFFSET_W-1:0]   req_frame_offset;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic signed [15:0]              rsp_sample_out;
   logic                            rsp_frame_ready;
   logic [ofrb_pkg::STATUS_W-1:0]   rsp_status;
   logic                            rsp_overrun;

   // predicted ring state
   logic [15:0]                     sample_mem [DEPTH];
   logic [13:0]                     wr_ptr       = '0;
   logic [13:0]                     win_start    = '0;
   logic [14:0]                     fill_cnt     = '0;
   logic                            overrun_seen = 1'b0;
   logic [ofrb_pkg::CFG_W-1:0]      frame_reg    = ofrb_pkg::FRAME_SIZE_RESET;
   logic [ofrb_pkg::CFG_W-1:0]      hop_reg      = ofrb_pkg::HOP_SIZE_RESET;

   ring_word_type         due_words [$];
   int                    errors    = 0;
   bit                    req_gaps  = 1'b0;
   bit                    rsp_gaps  = 1'b0;
   int                    rsp_hold  = 0;

   overlapping_frame_ring_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_sample_in    (req_sample_in),
      .req_frame_offset (req_frame_offset),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_frame_ready  (rsp_frame_ready),
      .rsp_status       (rsp_status),
      .rsp_overrun      (rsp_overrun)
   );

   always #2 clock = ~clock;

   function automatic int unsigned eff_frame();
      int unsigned f;
      f = frame_reg;
      if (f == 0) f = 1;
      if (f > MAX_FRAME) f = MAX_FRAME;
      return f;
   endfunction

   function automatic int unsigned eff_hop(int unsigned f);
      int unsigned h;
      h = hop_reg;
      if (h == 0) h = 1;
      if (h > f) h = f;
      return h;
   endfunction

   // Advance the predicted ring by one accepted word and queue the word it must return.
   function automatic void step_ring(ofrb_pkg::cmd_type cmd, logic [15:0] s, logic [11:0] off);
      int unsigned   f;
      int unsigned   h;
      bit            was_ready;
      logic [13:0]   idx;
      ring_word_type w;
      f = eff_frame();
      h = eff_hop(f);
      was_ready = (fill_cnt >= f);
      w = '{sample: '0, frame_ready: 1'b0, status: ofrb_pkg::STAT_OK, overrun: 1'b0};
      case (cmd)
         ofrb_pkg::CMD_PUSH: begin
            sample_mem[wr_ptr] = s;
            wr_ptr = wr_ptr + 14'd1;
            if (fill_cnt >= DEPTH)
               overrun_seen = 1'b1;
            else
               fill_cnt = fill_cnt + 15'd1;
         end
         ofrb_pkg::CMD_READ: begin
            if (!was_ready)
               w.status = ofrb_pkg::STAT_NOT_READY;
            else if (off >= f)
               w.status = ofrb_pkg::STAT_BAD_OFFSET;
            else begin
               idx = win_start + 14'(off);
               w.sample = sample_mem[idx];
            end
         end
         ofrb_pkg::CMD_RELEASE: begin
            if (!was_ready)
               w.status = ofrb_pkg::STAT_NOT_READY;
            else begin
               win_start = 14'(win_start + h);
               fill_cnt  = 15'(fill_cnt - h);
            end
         end
         default: ;
      endcase
      w.frame_ready = (fill_cnt >= f);
      w.overrun     = overrun_seen;
      due_words.push_back(w);
   endfunction

   function automatic int unsigned gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic int unsigned sender_gap();
      if (!req_gaps || $urandom_range(0, 2) != 0) return 0;
      return gap_len();
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endfunction

   // All tasks below start and end at a falling edge.
   task automatic send_word(ofrb_pkg::cmd_type cmd, logic [15:0] s, logic [11:0] off,
                            int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_sample_in    <= s;
      req_frame_offset <= off;
      do @(posedge clock); while (!req_ready);
      step_ring(cmd, s, off);
      @(negedge clock);
   endtask

   task automatic drain();
      if (req_valid)
         req_valid <= 1'b0;
      while (due_words.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [ofrb_pkg::CSR_IDX_W-1:0] idx, logic [ofrb_pkg::CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == ofrb_pkg::CSR_FRAME_SIZE)
         frame_reg = val;
      else if (idx == ofrb_pkg::CSR_HOP_SIZE)
         hop_reg = val;
      @(negedge clock);
   endtask

   task automatic set_config(logic [ofrb_pkg::CFG_W-1:0] frame, logic [ofrb_pkg::CFG_W-1:0] hop);
      drain();
      write_reg(ofrb_pkg::CSR_FRAME_SIZE, frame);
      write_reg(ofrb_pkg::CSR_HOP_SIZE, hop);
      csr_we <= 1'b0;
   endtask

   task automatic send_read(logic [11:0] off);
      send_word(ofrb_pkg::CMD_READ, 16'($urandom), off, sender_gap());
   endtask

   task automatic send_push(logic [15:0] s);
      send_word(ofrb_pkg::CMD_PUSH, s, 12'($urandom), sender_gap());
   endtask

   task automatic send_release();
      send_word(ofrb_pkg::CMD_RELEASE, 16'($urandom), 12'($urandom), sender_gap());
   endtask

   // Default registers: nothing is ready until a full 1024-sample frame is held.
   task automatic test_reset_state();
      send_read(12'd0);
      send_release();
      send_word(ofrb_pkg::CMD_NONE, 16'h7FFF, 12'hFFF, 0);
      send_push(16'h8000);
      send_read(12'd0);
   endtask

   task automatic test_small_frame();
      set_config(13'd4, 13'd2);
      send_push(16'h7FFF);
      send_push(16'h5555);
      send_push(16'hAAAA);
      send_read(12'd0);
      send_read(12'd3);
      send_read(12'd4);
      send_read(12'hFFF);
      send_release();
      send_read(12'd1);
      send_release();
      send_release();
   endtask

   task automatic test_clamps();
      // zero frame and zero hop both act as one
      set_config(13'd0, 13'd0);
      send_push(16'hFFFF);
      send_read(12'd0);
      send_read(12'd1);
      send_release();
      // hop larger than the frame is cut down to the frame
      set_config(13'd3, 13'h1FFF);
      @(negedge clock);
      write_reg(CSR_SPARE_A, 13'h1FFF);
      write_reg(CSR_SPARE_B, 13'h0000);
      csr_we <= 1'b0;
      send_push(16'h0001);
      send_release();
      send_read(12'd2);
      // oversize frame acts as the maximum frame
      set_config(13'h1FFF, 13'd1);
      send_push(16'h0000);
      send_read(12'd0);
   endtask

   // Stall the receiver long enough to fill the output stages and block the input.
   task automatic test_backpressure();
      set_config(13'd8, 13'd3);
      rsp_gaps = 1'b0;
      rsp_hold = 200;
      repeat (20) send_word(ofrb_pkg::CMD_PUSH, 16'($urandom), 12'($urandom), 0);
      repeat (20) send_word(ofrb_pkg::CMD_READ, 16'($urandom), 12'($urandom_range(0, 9)), 0);
      drain();
      repeat (10) send_read(12'($urandom_range(0, 7)));
      send_release();
   endtask

   task automatic random_phase(int unsigned count);
      int unsigned f;
      int unsigned r;
      logic [ofrb_pkg::CFG_W-1:0] fr;
      logic [ofrb_pkg::CFG_W-1:0] hp;
      case ($urandom_range(0, 9))
         0:       fr = '0;
         1:       fr = 13'd1;
         2:       fr = 13'($urandom_range(4097, 8191));
         default: fr = 13'($urandom_range(2, 64));
      endcase
      case ($urandom_range(0, 5))
         0:       hp = '0;
         1:       hp = 13'd1;
         2:       hp = fr;
         3:       hp = 13'($urandom_range(0, 8191));
         default: hp = 13'($urandom_range(1, (fr > 1) ? fr : 1));
      endcase
      set_config(fr, hp);
      req_gaps = ($urandom_range(0, 3) != 0);
      rsp_gaps = ($urandom_range(0, 3) != 0);
      repeat (count) begin
         f = eff_frame();
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 99) == 0)
            drain();
         if ($urandom_range(0, 9) == 0)
            send_word(ofrb_pkg::cmd_type'($urandom_range(0, 3)), 16'($urandom),
                      12'($urandom), sender_gap());
         else if (fill_cnt < f) begin
            if (r < 85)
               send_push(16'($urandom));
            else if (r < 95)
               send_read(12'($urandom));
            else
               send_release();
         end
         else if (r < 35)
            send_push(16'($urandom));
         else if (r < 75) begin
            if ($urandom_range(0, 9) == 0 && f <= 4095)
               send_read(12'($urandom_range(f, 4095)));
            else
               send_read(12'($urandom_range(0, f - 1)));
         end
         else if (r < 95)
            send_release();
         else
            send_word(ofrb_pkg::CMD_NONE, 16'($urandom), 12'($urandom), sender_gap());
      end
   endtask

   task automatic test_random();
      repeat (10) random_phase(195);
      rsp_gaps = 1'b1;
   endtask

   // receiver: random stalls, plus a long hold when a test asks for one
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold - 1) @(negedge clock);
            rsp_hold = 0;
         end
         else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len() - 1) @(negedge clock);
         end
         else
            rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_words
      ring_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word sample %h status %0d", $time, rsp_sample_out,
                     rsp_status);
         end
         else begin
            want = due_words.pop_front();
            check_field("sample_out", want.sample, rsp_sample_out);
            check_field("frame_ready", 16'(want.frame_ready), 16'(rsp_frame_ready));
            check_field("status", 16'(want.status), 16'(rsp_status));
            check_field("overrun", 16'(want.overrun), 16'(rsp_overrun));
         end
      end
   end

   initial begin : watchdog
      int quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no word moved for %0d cycles, %0d still due", $time, STALL_LIMIT,
               due_words.size());
      $display("overlapping_frame_ring_buffer: mismatch");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = ofrb_pkg::CSR_FRAME_SIZE;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_command      = ofrb_pkg::CMD_NONE;
      req_sample_in    = '0;
      req_frame_offset = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_small_frame();
      test_clamps();
      test_backpressure();
      test_random();
      drain();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("overlapping_frame_ring_buffer: match");
      else
         $display("overlapping_frame_ring_buffer: mismatch");
      $finish;
   end

endmodule
